>>> hdl/knn_classifier_unit_defines.svh
// Assertion macros for the kNN classifier unit
`ifndef KNN_CLASSIFIER_UNIT_DEFINES_SVH
`define KNN_CLASSIFIER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KNN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KNN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KNN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KNN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared types and constants of the kNN classifier unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package knn_pkg;
    localparam int TRAIN_DEPTH  = 128;
    localparam int K_MAX        = 16;
    localparam int NUM_FEATURES = 4;
    localparam int FEATURE_BITS = 8;
    localparam int NUM_CLASSES  = 3;
    localparam int NUM_LANES    = 4;
    localparam int ROW_BITS     = $clog2(TRAIN_DEPTH);
    localparam int RAM_DEPTH    = TRAIN_DEPTH / NUM_LANES;
    localparam int RAM_ABITS    = $clog2(RAM_DEPTH);
    localparam int LANE_BITS    = $clog2(NUM_LANES);
    localparam int DIST_BITS    = 18;
    localparam int VOTE_BITS    = 5;
    localparam int CLASS_BITS   = 2;
    localparam int TCNT_BITS    = 8;
    localparam int ROW_WORD     = NUM_FEATURES * FEATURE_BITS + CLASS_BITS;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    localparam logic [1:0] REG_METRIC = 2'd0;
    localparam logic [1:0] REG_KCOUNT = 2'd1;
    localparam logic [1:0] REG_TCOUNT = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [6:0]              row_index;
        logic [FEATURE_BITS-1:0] feature_0;
        logic [FEATURE_BITS-1:0] feature_1;
        logic [FEATURE_BITS-1:0] feature_2;
        logic [FEATURE_BITS-1:0] feature_3;
        logic [CLASS_BITS-1:0]   class_label;
    } t_in_item;

    typedef struct packed {
        logic [CLASS_BITS-1:0] predicted_class;
        logic [VOTE_BITS-1:0]  winning_votes;
        logic [DIST_BITS-1:0]  nearest_distance;
    } t_out_item;

    // one lane candidate to the merge stage
    typedef struct packed {
        logic                  valid;
        logic [DIST_BITS-1:0]  cand_dist;
        logic [CLASS_BITS-1:0] label;
    } t_cand;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_SCAN, ST_DRAIN, ST_VOTE, ST_OUT
    } t_state;
endpackage

>>> hdl/knn_ram.sv
// ----------------------------------------------------------------------------
// knn_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module knn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> hdl/knn_lane.sv
// ----------------------------------------------------------------------------
// knn_lane
// One distance lane: row bank, valid bits and registered distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module knn_lane import knn_pkg::*; (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_we,
    input  logic [RAM_ABITS-1:0]                 i_waddr,
    input  logic [ROW_WORD-1:0]                  i_wdata,
    input  logic [RAM_ABITS-1:0]                 i_raddr,
    input  logic                                 i_rd_en,
    input  logic                                 i_in_range,
    input  logic                                 i_metric,
    input  logic [NUM_FEATURES*FEATURE_BITS-1:0] i_query,
    output t_cand                                o_cand
);
    logic [ROW_WORD-1:0]  w_rdata;
    logic [RAM_DEPTH-1:0] r_valid;
    logic                 r_rd_ok;
    t_cand                r_cand;
    logic [DIST_BITS+1:0] w_sum;

    knn_ram #(.WIDTH(ROW_WORD), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_waddr), .i_wdata(i_wdata),
        .i_raddr(i_raddr), .o_rdata(w_rdata)
    );

    // track written rows and the read qualifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_we) r_valid[i_waddr] <= 1'b1;
            r_rd_ok <= i_rd_en && i_in_range && r_valid[i_raddr];
        end
    end

    // sum absolute or squared feature differences
    always_comb begin
        logic [FEATURE_BITS-1:0]   a, b, d;
        logic [2*FEATURE_BITS-1:0] sq;
        w_sum = '0;
        for (int f = 0; f < NUM_FEATURES; f++) begin
            a  = w_rdata[CLASS_BITS + f*FEATURE_BITS +: FEATURE_BITS];
            b  = i_query[f*FEATURE_BITS +: FEATURE_BITS];
            d  = (a > b) ? a - b : b - a;
            sq = d * d;
            w_sum = w_sum + (i_metric ? (DIST_BITS+2)'(d) : (DIST_BITS+2)'(sq));
        end
    end

    // register candidate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cand.valid <= 1'b0;
        else          r_cand.valid <= r_rd_ok;
        r_cand.cand_dist <= (w_sum > (DIST_BITS+2)'(DIST_MAX)) ? DIST_MAX
                                                               : w_sum[DIST_BITS-1:0];
        r_cand.label <= w_rdata[CLASS_BITS-1:0];
    end
    assign o_cand = r_cand;
endmodule

>>> hdl/knn_merge.sv
// ----------------------------------------------------------------------------
// knn_merge
// Insertion list of the k best; takes lane candidates one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module knn_merge import knn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic [VOTE_BITS-1:0]  i_k,
    input  t_cand                 i_cand,
    output logic [VOTE_BITS-1:0]  o_filled,
    output logic [DIST_BITS-1:0]  o_best_dist,
    output logic [CLASS_BITS-1:0] o_labels [K_MAX]
);
    logic [DIST_BITS-1:0]  r_dist [K_MAX];
    logic [CLASS_BITS-1:0] r_lab  [K_MAX];
    logic [VOTE_BITS-1:0]  r_filled;
    logic [K_MAX-1:0]      w_after;

    // slot i keeps its entry when its distance does not exceed the candidate
    always_comb begin
        for (int i = 0; i < K_MAX; i++)
            w_after[i] = (VOTE_BITS'(i) < r_filled) && (r_dist[i] <= i_cand.cand_dist);
    end

    // shift-insert, dropping anything at or beyond k
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_filled <= '0;
        end else if (i_cand.valid) begin
            for (int i = 0; i < K_MAX; i++) begin
                if (!w_after[i] && VOTE_BITS'(i) < i_k) begin
                    if (i == 0 || w_after[(i == 0) ? 0 : i-1]) begin
                        r_dist[i] <= i_cand.cand_dist;
                        r_lab[i]  <= i_cand.label;
                    end else begin
                        r_dist[i] <= r_dist[(i == 0) ? 0 : i-1];
                        r_lab[i]  <= r_lab[(i == 0) ? 0 : i-1];
                    end
                end
            end
            if (r_filled < i_k && !(VOTE_BITS'($countones(w_after)) >= i_k))
                r_filled <= r_filled + 1'b1;
        end
    end

    assign o_filled    = r_filled;
    assign o_best_dist = r_dist[0];
    assign o_labels    = r_lab;
endmodule

>>> hdl/knn_classifier_unit.sv
// A query result is offered after these steps: a clear state, a pass over the
// 32 bank addresses (read, distance register, then four lane candidates
// inserted one per cycle), a final scan step closing the scan, a vote state
// and a winner state. Input stalls until the result transfers, so a new query
// is not taken before the last result is through; a load gives no result.
// Reset (synchronous, active low) restores default registers and marks every
// stored row unwritten; no clearing pass is needed.
// ----------------------------------------------------------------------------
// knn_classifier_unit
// k-nearest-neighbor classifier over stored four-feature training rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "knn_classifier_unit_defines.svh"
module knn_classifier_unit import knn_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_in_item        i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output t_out_item       o_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data
);
    logic                   r_metric;
    logic [VOTE_BITS-1:0]   r_kcnt;
    logic [TCNT_BITS-1:0]   r_tcnt;
    t_state                 r_state, n_state;
    logic [NUM_FEATURES*FEATURE_BITS-1:0] r_query;
    logic [RAM_ABITS:0]     r_addr;
    logic [LANE_BITS+1:0]   r_sub;
    logic [VOTE_BITS-1:0]   r_k;
    logic [TCNT_BITS-1:0]   r_rows;
    t_cand                  w_cand [NUM_LANES];
    t_cand                  r_hold [NUM_LANES];
    t_cand                  w_sel;
    logic                   w_rd_en, w_accept, w_load, w_clear;
    logic [VOTE_BITS-1:0]   w_filled;
    logic [DIST_BITS-1:0]   w_best;
    logic [CLASS_BITS-1:0]  w_labels [K_MAX];
    logic [VOTE_BITS-1:0]   r_votes [NUM_CLASSES];
    logic [CLASS_BITS-1:0]  w_win;
    logic [VOTE_BITS-1:0]   w_win_votes;
    t_out_item              r_out;
    logic                   r_out_valid;
    logic [ROW_WORD-1:0]    w_wdata;
    logic [CLASS_BITS-1:0]  w_lab;

    assign w_accept = i_valid && !o_stall;
    assign w_load   = w_accept && i_data.func == FUNC_LOAD;
    assign o_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign w_lab    = (i_data.class_label >= CLASS_BITS'(NUM_CLASSES))
                      ? CLASS_BITS'(NUM_CLASSES-1) : i_data.class_label;
    assign w_wdata  = {i_data.feature_3, i_data.feature_2, i_data.feature_1,
                       i_data.feature_0, w_lab};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= 1'b0;
            r_kcnt   <= VOTE_BITS'(3);
            r_tcnt   <= TCNT_BITS'(120);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_METRIC: r_metric <= i_cfg_data[0];
                REG_KCOUNT: r_kcnt   <= i_cfg_data[VOTE_BITS-1:0];
                REG_TCOUNT: r_tcnt   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // lanes: row r lives in lane r mod NUM_LANES
    assign w_rd_en = (r_state == ST_SCAN) && r_sub == '0 &&
                     r_addr < (RAM_ABITS+1)'(RAM_DEPTH);
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        knn_lane u_lane (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_we(w_load && i_data.row_index[LANE_BITS-1:0] == LANE_BITS'(g)),
            .i_waddr(i_data.row_index[ROW_BITS-1:LANE_BITS]),
            .i_wdata(w_wdata),
            .i_raddr(r_addr[RAM_ABITS-1:0]),
            .i_rd_en(w_rd_en),
            .i_in_range(TCNT_BITS'({r_addr[RAM_ABITS-1:0], LANE_BITS'(g)}) < r_rows),
            .i_metric(r_metric), .i_query(r_query), .o_cand(w_cand[g])
        );
    end

    // capture all lane results at once; feed lane 0 directly, then the rest
    // from the hold registers, in row order to the merge stage
    always_ff @(posedge i_clk) begin
        if (r_sub == (LANE_BITS+2)'(2)) r_hold <= w_cand;
    end
    always_comb begin
        w_sel = '0;
        if (r_state == ST_SCAN) begin
            if (r_sub == (LANE_BITS+2)'(2))
                w_sel = w_cand[0];
            else if (r_sub > (LANE_BITS+2)'(2) && r_sub < (LANE_BITS+2)'(NUM_LANES+2))
                w_sel = r_hold[LANE_BITS'(r_sub - (LANE_BITS+2)'(2))];
        end
    end

    assign w_clear = (r_state == ST_CLEAR);
    knn_merge u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(w_clear), .i_k(r_k),
        .i_cand(w_sel), .o_filled(w_filled), .o_best_dist(w_best),
        .o_labels(w_labels)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept && i_data.func == FUNC_QUERY) n_state = ST_CLEAR;
            ST_CLEAR: n_state = ST_SCAN;
            ST_SCAN:  if (r_addr == (RAM_ABITS+1)'(RAM_DEPTH)) n_state = ST_VOTE;
            ST_VOTE:  n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state register, scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_addr <= '0;
                r_sub  <= '0;
            end else if (r_state == ST_SCAN) begin
                if (r_sub == (LANE_BITS+2)'(NUM_LANES+1)) begin
                    r_sub  <= '0;
                    r_addr <= r_addr + 1'b1;
                end else begin
                    r_sub <= r_sub + 1'b1;
                end
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_query <= {i_data.feature_3, i_data.feature_2, i_data.feature_1,
                        i_data.feature_0};
            r_k     <= (r_kcnt == '0) ? VOTE_BITS'(1)
                     : (r_kcnt > VOTE_BITS'(K_MAX)) ? VOTE_BITS'(K_MAX) : r_kcnt;
            r_rows  <= (r_tcnt > TCNT_BITS'(TRAIN_DEPTH)) ? TCNT_BITS'(TRAIN_DEPTH)
                                                          : r_tcnt;
        end
    end

    // vote count over the list
    always_ff @(posedge i_clk) begin
        logic [VOTE_BITS-1:0] v;
        if (r_state == ST_VOTE) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                v = '0;
                for (int i = 0; i < K_MAX; i++)
                    if (VOTE_BITS'(i) < w_filled && w_labels[i] == CLASS_BITS'(c))
                        v = v + 1'b1;
                r_votes[c] <= v;
            end
        end
    end

    // winner: the highest class holding the most votes
    always_comb begin
        w_win       = '0;
        w_win_votes = r_votes[0];
        for (int c = 1; c < NUM_CLASSES; c++) begin
            if (r_votes[c] >= w_win_votes) begin
                w_win       = CLASS_BITS'(c);
                w_win_votes = r_votes[c];
            end
        end
    end

    // hold result until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT) begin
            r_out_valid <= 1'b1;
            r_out.predicted_class  <= w_win;
            r_out.winning_votes    <= w_win_votes;
            r_out.nearest_distance <= (w_filled != '0) ? w_best : '0;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `KNN_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, o_stall)
    `KNN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `KNN_ASSERT_IMPL(a_k_bound, i_clk, i_rst_n, r_state == ST_VOTE, w_filled <= r_k)
endmodule
